// ===== design/osc_message_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the OSC message parser
// Immediate-consequence and next-cycle checks, reset aware.
// ----------------------------------------------------------------------------
`ifndef OSC_MESSAGE_PARSER_UNIT_MACROS_SVH
`define OSC_MESSAGE_PARSER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/osc_mp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSC message parser package
// Widths, character codes, result kinds, phases and record types.
// ----------------------------------------------------------------------------
package osc_mp_pkg;

  localparam int MAX_TAGS = 16;
  localparam int TAG_AW   = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int TAG_CW   = $clog2(MAX_TAGS + 1);

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 4;
  localparam int VALUE_W = 32;
  localparam int ARG_W   = 5;
  localparam int WORD_W  = VALUE_W - BYTE_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_INT   = 8'h69;  // 'i'
  localparam logic [BYTE_W-1:0] CH_FLOAT = 8'h66;  // 'f'
  localparam logic [BYTE_W-1:0] CH_STR   = 8'h73;  // 's'
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2c;  // ','

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDR_CHAR = 4'd0,
    KIND_ADDR_END  = 4'd1,
    KIND_INT       = 4'd2,
    KIND_FLOAT     = 4'd3,
    KIND_STR_CHAR  = 4'd4,
    KIND_STR_END   = 4'd5,
    KIND_MSG_END   = 4'd6,
    KIND_TRUNC     = 4'd7,
    KIND_TOO_MANY  = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    PH_ADDR      = 3'd0,
    PH_ADDR_PAD  = 3'd1,
    PH_TAG_FIRST = 3'd2,
    PH_TAGS      = 3'd3,
    PH_TAG_PAD   = 3'd4,
    PH_ARGS      = 3'd5,
    PH_ARG_PAD   = 3'd6,
    PH_DONE      = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    TAG_INT   = 2'd0,
    TAG_FLOAT = 2'd1,
    TAG_STR   = 2'd2
  } tag_e;

  // One known tag in the tag store: its type and its position in the tag string.
  typedef struct packed {
    tag_e              kind;
    logic [TAG_AW-1:0] idx;
  } tag_ent_t;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [ARG_W-1:0]   arg_number;
    logic               last;
  } res_t;

endpackage

// ===== design/osc_mp_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSC parser byte channel
// Valid/ready channel carrying one datagram byte per beat.
// ----------------------------------------------------------------------------
interface osc_mp_byte_if import osc_mp_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_datagram;

  modport source (
    output valid,
    output data_byte,
    output end_of_datagram,
    input  ready
  );

  modport sink (
    input  valid,
    input  data_byte,
    input  end_of_datagram,
    output ready
  );

endinterface

// ===== design/osc_mp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSC parser result channel
// Valid/ready channel carrying one parse result per beat.
// ----------------------------------------------------------------------------
interface osc_mp_res_if import osc_mp_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic [ARG_W-1:0]   arg_number;
  logic               last;

  modport source (
    output valid,
    output kind,
    output value,
    output arg_number,
    output last,
    input  ready
  );

  modport sink (
    input  valid,
    input  kind,
    input  value,
    input  arg_number,
    input  last,
    output ready
  );

endinterface

// ===== design/osc_message_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSC message parser
// Streams a datagram byte by byte and emits address characters, argument
// words and string characters, with end marks and error flags.
// ----------------------------------------------------------------------------
//  port    | dir | beat carries
//  --------+-----+------------------------------------------------------
//  in_i    | in  | data_byte, end_of_datagram
//  out_o   | out | kind, value, arg_number, last (0 to 2 beats per byte)
//
// One byte is taken per cycle while in_i.ready is high; a byte that yields two results needs two output
// beats, so sustained rate is one byte per cycle when at most one result per byte comes out and out_o.ready
// stays high, else set by the output port at one result per cycle.
// in_i.ready is high while the four-entry result queue has at least two free slots.
// The tag store is a 16-entry synchronous RAM read one entry ahead of the
// argument cursor, with write-to-read forwarding; no extra latency results.
// Reset is asynchronous and clears control state; the tag store is not swept.
// ----------------------------------------------------------------------------
`include "osc_message_parser_unit_macros.svh"

module osc_message_parser_unit import osc_mp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  osc_mp_byte_if.sink   in_i,
  osc_mp_res_if.source  out_o
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  phase_e             phase_q, phase_d, phase_n;
  logic [1:0]         pos_q, pos_d;
  logic [TAG_CW-1:0]  tcount_q, tcount_d;
  logic [TAG_CW-1:0]  kcount_q, kcount_d;
  logic [TAG_CW-1:0]  kcur_q, kcur_d, kcur_inc;
  logic [WORD_W-1:0]  word_q, word_d;
  logic               ovf_q, ovf_d;
  tag_ent_t           cur_q, cur_d, cur_n;

  tag_ent_t           tag_mem [MAX_TAGS];
  tag_ent_t           tag_rd_q;
  tag_ent_t           tag_wd;
  logic [TAG_AW-1:0]  tag_wa, tag_ra;
  logic               tag_we;

  res_t               q_mem [Q_DEPTH];
  logic [Q_AW-1:0]    q_wr_q, q_wr_d, q_rd_q, q_rd_d;
  logic [Q_CW-1:0]    q_cnt_q, q_cnt_d;

  // --------------------------------------------------------------------------
  // Byte decode
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] byte_v;
  logic              eod, byte_acc, res_pop;
  logic              byte_nz, aligned, in_tags, tag_take, tag_room, tag_known;
  logic              over_hit, cur_str, from_tags, advance, seek, seek_ok;
  tag_e              tag_kind;

  assign byte_v   = in_i.data_byte;
  assign eod      = in_i.end_of_datagram;
  assign byte_acc = in_i.valid && in_i.ready;
  assign res_pop  = out_o.valid && out_o.ready;

  assign byte_nz   = byte_v != '0;
  assign aligned   = pos_q == 2'd3;
  assign in_tags   = (phase_q == PH_TAG_FIRST) || (phase_q == PH_TAGS);
  assign tag_take  = in_tags && byte_nz && !(phase_q == PH_TAG_FIRST && byte_v == CH_COMMA);
  assign tag_room  = tcount_q < TAG_CW'(MAX_TAGS);
  assign tag_known = (byte_v == CH_INT) || (byte_v == CH_FLOAT) || (byte_v == CH_STR);
  assign tag_kind  = (byte_v == CH_INT) ? TAG_INT : (byte_v == CH_FLOAT) ? TAG_FLOAT : TAG_STR;
  assign over_hit  = tag_take && !tag_room && !ovf_q;
  assign cur_str   = cur_q.kind == TAG_STR;
  assign kcur_inc  = kcur_q + 1'b1;

  // Argument list is entered from the tag string or the cursor steps on.
  assign from_tags = aligned && ((in_tags && !byte_nz) || phase_q == PH_TAG_PAD);
  assign advance   = aligned && ((phase_q == PH_ARGS && (!cur_str || !byte_nz)) ||
                                 phase_q == PH_ARG_PAD);
  assign seek      = from_tags || advance;
  assign seek_ok   = from_tags ? (kcount_q != '0) : (kcur_inc < kcount_q);
  assign cur_n     = advance ? tag_rd_q : cur_q;

  // --------------------------------------------------------------------------
  // Next phase
  // --------------------------------------------------------------------------
  always_comb begin
    phase_n = phase_q;
    case (phase_q)
      PH_ADDR: begin
        if (!byte_nz) phase_n = aligned ? PH_TAG_FIRST : PH_ADDR_PAD;
      end
      PH_ADDR_PAD: begin
        if (aligned) phase_n = PH_TAG_FIRST;
      end
      PH_TAG_FIRST, PH_TAGS: begin
        if (byte_nz) phase_n = PH_TAGS;
        else if (!aligned) phase_n = PH_TAG_PAD;
      end
      PH_ARGS: begin
        if (cur_str && !byte_nz && !aligned) phase_n = PH_ARG_PAD;
      end
      default: ;
    endcase
    if (seek) phase_n = seek_ok ? PH_ARGS : PH_DONE;

    phase_d = phase_q;
    if (byte_acc) phase_d = eod ? PH_ADDR : phase_n;
  end

  // --------------------------------------------------------------------------
  // Results of the current byte
  // --------------------------------------------------------------------------
  res_t       prim, mend, trunc, slot0, slot1;
  logic       prim_v, mend_v, trunc_v;
  logic [1:0] n_res, n_push;

  always_comb begin
    prim   = '0;
    prim_v = 1'b0;
    case (phase_q)
      PH_ADDR: begin
        prim_v     = 1'b1;
        prim.kind  = byte_nz ? KIND_ADDR_CHAR : KIND_ADDR_END;
        prim.value = VALUE_W'(byte_v);
      end
      PH_TAG_FIRST, PH_TAGS: begin
        prim_v    = over_hit;
        prim.kind = KIND_TOO_MANY;
      end
      PH_ARGS: begin
        prim.arg_number = ARG_W'(cur_q.idx);
        if (cur_str) begin
          prim_v     = 1'b1;
          prim.kind  = byte_nz ? KIND_STR_CHAR : KIND_STR_END;
          prim.value = VALUE_W'(byte_v);
        end else begin
          prim_v     = aligned;
          prim.kind  = (cur_q.kind == TAG_INT) ? KIND_INT : KIND_FLOAT;
          prim.value = {word_q, byte_v};
        end
      end
      default: ;
    endcase

    mend            = '0;
    mend_v          = seek && !seek_ok;
    mend.kind       = KIND_MSG_END;
    mend.arg_number = ARG_W'(tcount_q);

    trunc      = '0;
    trunc_v    = eod && phase_n != PH_DONE;
    trunc.kind = KIND_TRUNC;
    if (phase_n == PH_ARGS || phase_n == PH_ARG_PAD) trunc.arg_number = ARG_W'(cur_n.idx);

    slot0 = prim_v ? prim : (mend_v ? mend : trunc);
    slot1 = (prim_v && mend_v) ? mend : trunc;
    n_res = {1'b0, prim_v} + {1'b0, mend_v} + {1'b0, trunc_v};
    slot0.last = n_res == 2'd1;
    slot1.last = 1'b1;
    n_push = byte_acc ? n_res : 2'd0;
  end

  // --------------------------------------------------------------------------
  // Running state update
  // --------------------------------------------------------------------------
  assign tag_we = byte_acc && tag_take && tag_room && tag_known;
  assign tag_wa = TAG_AW'(kcount_q);
  assign tag_wd = '{kind: tag_kind, idx: TAG_AW'(tcount_q)};

  always_comb begin
    pos_d    = pos_q;
    tcount_d = tcount_q;
    kcount_d = kcount_q;
    kcur_d   = kcur_q;
    word_d   = word_q;
    ovf_d    = ovf_q;
    cur_d    = cur_q;
    if (byte_acc) begin
      pos_d = pos_q + 2'd1;
      if (tag_take && tag_room) tcount_d = tcount_q + 1'b1;
      if (tag_we) kcount_d = kcount_q + 1'b1;
      if (over_hit) ovf_d = 1'b1;
      if (advance) kcur_d = kcur_inc;
      if (phase_q == PH_ARGS && !cur_str) begin
        word_d = aligned ? '0 : {word_q[WORD_W-BYTE_W-1:0], byte_v};
      end
      // Entry 0 goes straight to the cursor register; later ones come from the RAM.
      if (tag_we && kcount_q == '0) cur_d = tag_wd;
      else if (advance) cur_d = tag_rd_q;
      if (eod) begin
        pos_d    = '0;
        tcount_d = '0;
        kcount_d = '0;
        kcur_d   = '0;
        word_d   = '0;
        ovf_d    = 1'b0;
      end
    end
  end

  // Prefetch the entry after the cursor.
  assign tag_ra = TAG_AW'(kcur_d + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ADDR;
      pos_q    <= '0;
      tcount_q <= '0;
      kcount_q <= '0;
      kcur_q   <= '0;
      word_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      tcount_q <= tcount_d;
      kcount_q <= kcount_d;
      kcur_q   <= kcur_d;
      word_q   <= word_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Tag store: one write and one registered read per cycle, write forwarded.
  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (tag_we && tag_wa == tag_ra) tag_rd_q <= tag_wd;
    else tag_rd_q <= tag_mem[tag_ra];
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  assign in_i.ready = q_cnt_q <= Q_CW'(Q_DEPTH - 2);

  always_comb begin
    q_wr_d  = q_wr_q + Q_AW'(n_push);
    q_rd_d  = res_pop ? q_rd_q + 1'b1 : q_rd_q;
    q_cnt_d = q_cnt_q + Q_CW'(n_push) - Q_CW'(res_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      q_wr_q  <= q_wr_d;
      q_rd_q  <= q_rd_d;
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) q_mem[q_wr_q] <= slot0;
    if (n_push == 2'd2) q_mem[Q_AW'(q_wr_q + 1'b1)] <= slot1;
  end

  assign out_o.valid      = q_cnt_q != '0;
  assign out_o.kind       = q_mem[q_rd_q].kind;
  assign out_o.value      = q_mem[q_rd_q].value;
  assign out_o.arg_number = q_mem[q_rd_q].arg_number;
  assign out_o.last       = q_mem[q_rd_q].last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `OMP_ASSERT_IMP(a_cursor_in_range, clk_i, rst_ni, phase_q == PH_ARGS || phase_q == PH_ARG_PAD, kcur_q < kcount_q, "argument cursor past known tags")
  `OMP_ASSERT_IMP(a_known_le_all, clk_i, rst_ni, 1'b1, kcount_q <= tcount_q, "known tag count above tag count")
  `OMP_ASSERT_IMP(a_queue_bound, clk_i, rst_ni, 1'b1, q_cnt_q <= Q_CW'(Q_DEPTH), "result queue overrun")
  `OMP_ASSERT_NXT(a_eod_clears, clk_i, rst_ni, byte_acc && eod, phase_q == PH_ADDR && pos_q == 2'd0 && tcount_q == '0, "parser not cleared after datagram end")

endmodule
